### rtl/ttcb_pkg.sv
`timescale 1ns / 1ps

package ttcb_pkg;

  // default screen geometry
  localparam int DEF_COLS = 60;
  localparam int DEF_ROWS = 24;

  // command codes
  localparam logic [3:0] CMD_PUT     = 4'd0;
  localparam logic [3:0] CMD_CLEAR   = 4'd1;
  localparam logic [3:0] CMD_SCROLL  = 4'd2;
  localparam logic [3:0] CMD_FWD     = 4'd3;
  localparam logic [3:0] CMD_NEWLINE = 4'd4;
  localparam logic [3:0] CMD_LF      = 4'd5;
  localparam logic [3:0] CMD_SHOW    = 4'd6;
  localparam logic [3:0] CMD_HIDE    = 4'd7;
  localparam logic [3:0] CMD_READ    = 4'd8;

  // special characters and cursor marking
  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CURSOR_MARK = 8'h80;

  // cursor update operations
  localparam logic [2:0] CUR_NONE    = 3'd0;
  localparam logic [2:0] CUR_COL0    = 3'd1;
  localparam logic [2:0] CUR_HOME    = 3'd2;
  localparam logic [2:0] CUR_FWD     = 3'd3;
  localparam logic [2:0] CUR_NEWLINE = 3'd4;
  localparam logic [2:0] CUR_LF      = 3'd5;

  // memory write sources
  localparam logic [1:0] WR_ZERO = 2'd0;
  localparam logic [1:0] WR_CHAR = 2'd1;
  localparam logic [1:0] WR_COPY = 2'd2;

  // memory read sources
  localparam logic [1:0] RD_CELL  = 2'd0;
  localparam logic [1:0] RD_COPY0 = 2'd1;
  localparam logic [1:0] RD_COPY1 = 2'd2;

  // sweep counter operations
  localparam logic [1:0] IDX_HOLD = 2'd0;
  localparam logic [1:0] IDX_CLR  = 2'd1;
  localparam logic [1:0] IDX_INC  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       latch;
    logic [2:0] cur_op;
    logic       show;
    logic       hide;
    logic       wr_en;
    logic [1:0] wr_src;
    logic       rd_en;
    logic [1:0] rd_src;
    logic [1:0] idx_op;
    logic       out_load;
  } ttcb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [3:0] cmd;
    logic       ch_cr;
    logic       ch_lf;
    logic       col_end;
    logic       row_end;
    logic       idx_last_copy;
    logic       idx_last;
    logic       out_blocked;
  } ttcb_stat_t;

endpackage

### rtl/ttcb_ram.sv
`timescale 1ns / 1ps

module ttcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1440
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

### rtl/ttcb_ctrl.sv
`timescale 1ns / 1ps

module ttcb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ttcb_pkg::ttcb_stat_t stat,
  output ttcb_pkg::ttcb_cmd_t  cmd
);

  import ttcb_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_CLEAR = 4'd3;
  localparam logic [3:0] S_PRIME = 4'd4;
  localparam logic [3:0] S_COPY  = 4'd5;
  localparam logic [3:0] S_ZERO  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0] state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // new transactions only in idle
  assign in_stall = (state_r != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_ZERO;
        cmd.idx_op = IDX_INC;
        if (stat.idx_last) begin
          cmd.idx_op = IDX_CLR;
          state_nxt  = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (stat.cmd)
          CMD_PUT: begin
            if (stat.ch_cr) begin
              cmd.cur_op = CUR_COL0;
            end else if (stat.ch_lf) begin
              cmd.cur_op = CUR_NEWLINE;
              if (stat.row_end) state_nxt = S_PRIME;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_src = WR_CHAR;
              cmd.cur_op = CUR_FWD;
              if (stat.col_end && stat.row_end) state_nxt = S_PRIME;
            end
          end
          CMD_CLEAR: begin
            cmd.cur_op = CUR_HOME;
            state_nxt  = S_CLEAR;
          end
          CMD_SCROLL: begin
            state_nxt = S_PRIME;
          end
          CMD_FWD: begin
            cmd.cur_op = CUR_FWD;
            if (stat.col_end && stat.row_end) state_nxt = S_PRIME;
          end
          CMD_NEWLINE: begin
            cmd.cur_op = CUR_NEWLINE;
            if (stat.row_end) state_nxt = S_PRIME;
          end
          CMD_LF: begin
            cmd.cur_op = CUR_LF;
            if (stat.row_end) state_nxt = S_PRIME;
          end
          CMD_SHOW: cmd.show = 1'b1;
          CMD_HIDE: cmd.hide = 1'b1;
          CMD_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = RD_CELL;
          end
          default: ;
        endcase
      end
      S_CLEAR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_ZERO;
        cmd.idx_op = IDX_INC;
        if (stat.idx_last) begin
          cmd.idx_op = IDX_CLR;
          state_nxt  = S_DONE;
        end
      end
      // fetch the first cell of the second row
      S_PRIME: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_COPY0;
        state_nxt  = S_COPY;
      end
      // move each cell one row up while fetching the next
      S_COPY: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_COPY;
        cmd.idx_op = IDX_INC;
        if (stat.idx_last_copy) begin
          state_nxt = S_ZERO;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_COPY1;
        end
      end
      // blank the bottom row
      S_ZERO: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = WR_ZERO;
        cmd.idx_op = IDX_INC;
        if (stat.idx_last) begin
          cmd.idx_op = IDX_CLR;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_blocked) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### rtl/ttcb_dp.sv
`timescale 1ns / 1ps

module ttcb_dp #(
  parameter int COLS = ttcb_pkg::DEF_COLS,
  parameter int ROWS = ttcb_pkg::DEF_ROWS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [3:0]                in_command,
  input  logic [7:0]                in_char_code,
  input  logic [$clog2(ROWS)-1:0]   in_read_row,
  input  logic [$clog2(COLS)-1:0]   in_read_col,
  input  ttcb_pkg::ttcb_cmd_t       cmd,
  output ttcb_pkg::ttcb_stat_t      stat,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [7:0]                out_cell_value,
  output logic [$clog2(COLS)-1:0]   out_cursor_col,
  output logic [$clog2(ROWS)-1:0]   out_cursor_row,
  output logic                      out_cursor_visible
);

  import ttcb_pkg::*;

  localparam int CW       = $clog2(COLS);
  localparam int RW       = $clog2(ROWS);
  localparam int TOTAL    = ROWS * COLS;
  localparam int AW       = $clog2(TOTAL);
  localparam int COPY_END = (ROWS - 1) * COLS - 1;
  localparam logic [AW-1:0] COLS_A = AW'(COLS);

  // latched transaction
  logic [3:0]    cmd_r;
  logic [7:0]    ch_r;
  logic [RW-1:0] rrow_r;
  logic [CW-1:0] rcol_r;

  // cursor and sweep state
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt, row_adv;
  logic          shown_r;
  logic [AW-1:0] idx_r, idx_nxt;

  // output register
  logic          out_valid_r;
  logic [7:0]    out_cell_r;
  logic [CW-1:0] out_col_r;
  logic [RW-1:0] out_row_r;
  logic          out_vis_r;

  // memory ports
  logic          ram_wr_en, ram_rd_en;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [7:0]    ram_wr_data, ram_q;

  logic          col_end, row_end, rd_in_range, mark;
  logic [AW-1:0] cur_addr, cell_addr;
  logic [AW:0]   copy_rd;
  logic [7:0]    cell_nxt;

  // capture the transaction fields
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r  <= in_command;
      ch_r   <= in_char_code;
      rrow_r <= in_read_row;
      rcol_r <= in_read_col;
    end
  end

  assign col_end = (col_r == CW'(COLS - 1));
  assign row_end = (row_r == RW'(ROWS - 1));
  assign row_adv = row_end ? row_r : row_r + 1'b1;

  // cursor movement
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    case (cmd.cur_op)
      CUR_COL0: col_nxt = '0;
      CUR_HOME: begin
        col_nxt = '0;
        row_nxt = '0;
      end
      CUR_FWD: begin
        if (col_end) begin
          col_nxt = '0;
          row_nxt = row_adv;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      CUR_NEWLINE: begin
        col_nxt = '0;
        row_nxt = row_adv;
      end
      CUR_LF:  row_nxt = row_adv;
      default: ;
    endcase
  end

  // sweep counter
  always_comb begin
    case (cmd.idx_op)
      IDX_CLR: idx_nxt = '0;
      IDX_INC: idx_nxt = idx_r + 1'b1;
      default: idx_nxt = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      shown_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      idx_r <= idx_nxt;
      if (cmd.show) begin
        shown_r <= 1'b1;
      end else if (cmd.hide) begin
        shown_r <= 1'b0;
      end
    end
  end

  // memory addressing
  assign cur_addr    = AW'(row_r) * COLS_A + AW'(col_r);
  assign cell_addr   = AW'(rrow_r) * COLS_A + AW'(rcol_r);
  assign rd_in_range = ({1'b0, rrow_r} < (RW + 1)'(ROWS)) &&
                       ({1'b0, rcol_r} < (CW + 1)'(COLS));
  assign copy_rd     = {1'b0, idx_r} + (AW + 1)'(COLS) +
                       (AW + 1)'(cmd.rd_src == RD_COPY1);

  assign ram_rd_en   = cmd.rd_en && ((cmd.rd_src != RD_CELL) || rd_in_range);
  assign ram_rd_addr = (cmd.rd_src == RD_CELL) ? cell_addr : copy_rd[AW-1:0];
  assign ram_wr_en   = cmd.wr_en;

  always_comb begin
    case (cmd.wr_src)
      WR_CHAR: begin
        ram_wr_addr = cur_addr;
        ram_wr_data = ch_r;
      end
      WR_COPY: begin
        ram_wr_addr = idx_r;
        ram_wr_data = ram_q;
      end
      default: begin
        ram_wr_addr = idx_r;
        ram_wr_data = 8'h00;
      end
    endcase
  end

  ttcb_ram #(
    .WIDTH (8),
    .DEPTH (TOTAL)
  ) u_screen (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_q)
  );

  // status back to the controller
  always_comb begin
    stat.cmd           = cmd_r;
    stat.ch_cr         = (ch_r == CHAR_CR);
    stat.ch_lf         = (ch_r == CHAR_LF);
    stat.col_end       = col_end;
    stat.row_end       = row_end;
    stat.idx_last_copy = (idx_r == AW'(COPY_END));
    stat.idx_last      = (idx_r == AW'(TOTAL - 1));
    stat.out_blocked   = out_valid_r && out_stall;
  end

  // read value with cursor inversion
  assign mark     = shown_r && (rrow_r == row_r) && (rcol_r == col_r);
  assign cell_nxt = ((cmd_r == CMD_READ) && rd_in_range) ?
                    (ram_q ^ (mark ? CURSOR_MARK : 8'h00)) : 8'h00;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cell_r <= cell_nxt;
      out_col_r  <= col_r;
      out_row_r  <= row_r;
      out_vis_r  <= shown_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cell_value     = out_cell_r;
  assign out_cursor_col     = out_col_r;
  assign out_cursor_row     = out_row_r;
  assign out_cursor_visible = out_vis_r;

`ifndef SYNTH
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < (CW + 1)'(COLS))
    else $error("cursor column beyond row end");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, row_r} < (RW + 1)'(ROWS))
    else $error("cursor row beyond screen");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result loaded over a held result");

  a_copy_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && (cmd.wr_src == WR_COPY)) |-> $past(ram_rd_en))
    else $error("scroll copy without a fetch in the previous cycle");
`endif

endmodule

### rtl/text_terminal_char_buffer.sv
`timescale 1ns / 1ps

// Character screen of ROWS lines by COLS bytes with a cursor, for a glass
// terminal. Each input transaction carries one command (put character, clear,
// scroll up, cursor forward, newline, line feed, show or hide cursor, read
// cell) and yields exactly one result transaction with the read value and the
// cursor state after the command. The screen lives in a single memory with one
// write and one registered read port, so the cost is set by that port: after
// reset a pass clears all ROWS*COLS cells before the first command is taken.
// Simple commands and reads pass through an execute and a done state, which
// loads the result register. Clear adds a pass that blanks every cell, and any
// command that scrolls (scroll up, or moving below the last line) adds a
// priming read and a pass that moves or blanks every cell, one per cycle. One
// command is in progress at a time; a finished result waits in the output
// register while the next command is accepted.
module text_terminal_char_buffer #(
  parameter int COLS = ttcb_pkg::DEF_COLS,
  parameter int ROWS = ttcb_pkg::DEF_ROWS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [3:0]              in_command,
  input  logic [7:0]              in_char_code,
  input  logic [$clog2(ROWS)-1:0] in_read_row,
  input  logic [$clog2(COLS)-1:0] in_read_col,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_cell_value,
  output logic [$clog2(COLS)-1:0] out_cursor_col,
  output logic [$clog2(ROWS)-1:0] out_cursor_row,
  output logic                    out_cursor_visible
);

  import ttcb_pkg::*;

  ttcb_cmd_t  cmd;
  ttcb_stat_t stat;

  // sequencing
  ttcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // cursor, screen memory and result register
  ttcb_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_command         (in_command),
    .in_char_code       (in_char_code),
    .in_read_row        (in_read_row),
    .in_read_col        (in_read_col),
    .cmd                (cmd),
    .stat               (stat),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_cell_value     (out_cell_value),
    .out_cursor_col     (out_cursor_col),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_visible (out_cursor_visible)
  );

endmodule

### dv/text_terminal_char_buffer_test.sv
`timescale 1ns / 1ps

module text_terminal_char_buffer_test;
  import ttcb_pkg::*;

  localparam int ROW_W = $clog2(DEF_ROWS);
  localparam int COL_W = $clog2(DEF_COLS);
  localparam int ROW_SPAN = 1 << ROW_W;
  localparam int COL_SPAN = 1 << COL_W;
  localparam int RANDOM_ITEMS = 1600;
  localparam int PHASES = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 2000;
  localparam int MAX_PRINTS = 40;
  localparam longint CYCLE_LIMIT = 12_000_000;
  localparam logic [3:0] CMD_FIRST_SPARE = CMD_READ + 4'd1;
  localparam logic [3:0] CMD_LAST_SPARE = 4'hF;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_A = 8'h41;

  // where a read lands: fixed, on the cursor, or just left of it
  typedef enum logic [1:0] {AIM_NONE, AIM_CURSOR, AIM_LEFT} aim_t;

  typedef struct {
    logic [3:0]       command;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_col;
    aim_t             aim;
  } screen_cmd_t;

  typedef struct {
    logic [7:0]       cell_value;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic             cursor_visible;
  } cell_report_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [3:0]       in_command = '0;
  logic [7:0]       in_char_code = '0;
  logic [ROW_W-1:0] in_read_row = '0;
  logic [COL_W-1:0] in_read_col = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_cell_value;
  logic [COL_W-1:0] out_cursor_col;
  logic [ROW_W-1:0] out_cursor_row;
  logic             out_cursor_visible;

  // model of the screen and cursor
  logic [7:0]   screen [DEF_ROWS][DEF_COLS];
  int           cur_col;
  int           cur_row;
  bit           cur_shown;

  screen_cmd_t  command_q[$];
  cell_report_t cell_reports[$];
  screen_cmd_t  next_cmd;
  cell_report_t got_report;
  cell_report_t want_report;

  bit     in_fire;
  int     send_idle_pct;
  int     stall_pct;
  int     holds_requested;
  int     holds_started;
  int     hold_left;
  int     items_queued;
  int     items_taken;
  int     results_seen;
  int     mismatches;
  longint cycles;

  text_terminal_char_buffer DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_char_code       (in_char_code),
    .in_read_row        (in_read_row),
    .in_read_col        (in_read_col),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cell_value     (out_cell_value),
    .out_cursor_col     (out_cursor_col),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_visible (out_cursor_visible)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // random byte for fields that a command ignores
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // screen model: scrolling and cursor motion
  function automatic void shift_screen_up();
    for (int r = 0; r < DEF_ROWS - 1; r++) begin
      for (int c = 0; c < DEF_COLS; c++) begin
        screen[r][c] = screen[r + 1][c];
      end
    end
    for (int c = 0; c < DEF_COLS; c++) begin
      screen[DEF_ROWS - 1][c] = '0;
    end
  endfunction

  function automatic void move_down();
    if (cur_row + 1 > DEF_ROWS - 1) begin
      cur_row = DEF_ROWS - 1;
      shift_screen_up();
    end else begin
      cur_row++;
    end
  endfunction

  function automatic void return_and_down();
    cur_col = 0;
    move_down();
  endfunction

  function automatic void step_right();
    if (cur_col + 1 > DEF_COLS - 1) begin
      return_and_down();
    end else begin
      cur_col++;
    end
  endfunction

  function automatic void blank_screen();
    for (int r = 0; r < DEF_ROWS; r++) begin
      for (int c = 0; c < DEF_COLS; c++) begin
        screen[r][c] = '0;
      end
    end
  endfunction

  // applies one command to the model, returns the resulting cell and cursor state
  function automatic cell_report_t apply_command(logic [3:0] cmd, logic [7:0] ch,
                                                 logic [ROW_W-1:0] rr,
                                                 logic [COL_W-1:0] rc);
    cell_report_t rep;
    rep.cell_value = '0;
    case (cmd)
      CMD_PUT: begin
        if (ch == CHAR_CR) begin
          cur_col = 0;
        end else if (ch == CHAR_LF) begin
          return_and_down();
        end else begin
          screen[cur_row][cur_col] = ch;
          step_right();
        end
      end
      CMD_CLEAR: begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;
      end
      CMD_SCROLL:  shift_screen_up();
      CMD_FWD:     step_right();
      CMD_NEWLINE: return_and_down();
      CMD_LF:      move_down();
      CMD_SHOW:    cur_shown = 1'b1;
      CMD_HIDE:    cur_shown = 1'b0;
      CMD_READ: begin
        if (rr < DEF_ROWS && rc < DEF_COLS) begin
          rep.cell_value = screen[rr][rc];
          if (cur_shown && rr == cur_row && rc == cur_col) begin
            rep.cell_value = rep.cell_value ^ CURSOR_MARK;
          end
        end
      end
      default: ;
    endcase
    rep.cursor_col = cur_col[COL_W-1:0];
    rep.cursor_row = cur_row[ROW_W-1:0];
    rep.cursor_visible = cur_shown;
    return rep;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("mismatch at result %0d: %s", results_seen, msg);
    end
  endtask

  task automatic push_item(input logic [3:0] cmd, input logic [7:0] ch,
                           input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                           input aim_t aim);
    screen_cmd_t item;
    item.command = cmd;
    item.char_code = ch;
    item.read_row = rr;
    item.read_col = rc;
    item.aim = aim;
    command_q.push_back(item);
    items_queued++;
  endtask

  // non-read command with random content in the fields it ignores
  task automatic push_plain(input logic [3:0] cmd, input logic [7:0] ch);
    push_item(cmd, ch, ROW_W'($urandom_range(0, ROW_SPAN - 1)),
              COL_W'($urandom_range(0, COL_SPAN - 1)), AIM_NONE);
  endtask

  task automatic push_read();
    int pick;
    logic [ROW_W-1:0] rr;
    logic [COL_W-1:0] rc;
    pick = $urandom_range(0, 9);
    if ($urandom_range(0, 6) == 0) begin
      rr = ROW_W'($urandom_range(0, ROW_SPAN - 1));
      rc = COL_W'($urandom_range(0, COL_SPAN - 1));
    end else begin
      rr = ROW_W'($urandom_range(0, DEF_ROWS - 1));
      rc = COL_W'($urandom_range(0, DEF_COLS - 1));
    end
    if (pick < 4) begin
      push_item(CMD_READ, rand_byte(), rr, rc, AIM_CURSOR);
    end else if (pick < 6) begin
      push_item(CMD_READ, rand_byte(), rr, rc, AIM_LEFT);
    end else begin
      push_item(CMD_READ, rand_byte(), rr, rc, AIM_NONE);
    end
  endtask

  // lines of text with reads mixed in, plus the odd control command and noise
  task automatic queue_random(input int count);
    int target;
    int pick;
    int len;
    logic [7:0] ch;
    target = items_queued + count;
    while (items_queued < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 130) : $urandom_range(1, 30);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 4) == 0) push_read();
          ch = ($urandom_range(0, 9) == 0) ? rand_byte()
                                           : 8'($urandom_range(CHAR_SPACE, CHAR_TILDE));
          push_plain(CMD_PUT, ch);
        end
        case ($urandom_range(0, 4))
          0: begin
            push_plain(CMD_PUT, CHAR_CR);
            push_plain(CMD_PUT, CHAR_LF);
          end
          1: push_plain(CMD_PUT, CHAR_LF);
          2: push_plain(CMD_NEWLINE, rand_byte());
          3: push_plain(CMD_PUT, CHAR_CR);
          default: ;
        endcase
      end else if (pick < 70) begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) push_read();
      end else if (pick < 78) begin
        push_plain($urandom_range(0, 1) ? CMD_SHOW : CMD_HIDE, rand_byte());
      end else if (pick < 84) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) push_plain(CMD_FWD, rand_byte());
      end else if (pick < 88) begin
        push_plain(CMD_LF, rand_byte());
      end else if (pick < 91) begin
        push_plain(CMD_NEWLINE, rand_byte());
      end else if (pick < 93) begin
        push_plain(CMD_SCROLL, rand_byte());
      end else if (pick < 94) begin
        push_plain(CMD_CLEAR, rand_byte());
      end else if (pick < 97) begin
        push_plain(4'($urandom_range(CMD_FIRST_SPARE, CMD_LAST_SPARE)), rand_byte());
      end else begin
        push_plain(CMD_PUT, rand_byte());
      end
    end
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || cell_reports.size() != 0) @(negedge clk);
  endtask

  // driver: presents queued commands at the falling edge
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (command_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_cmd = command_q.pop_front();
        if (next_cmd.aim == AIM_CURSOR) begin
          next_cmd.read_row = cur_row[ROW_W-1:0];
          next_cmd.read_col = cur_col[COL_W-1:0];
        end else if (next_cmd.aim == AIM_LEFT) begin
          next_cmd.read_row = cur_row[ROW_W-1:0];
          next_cmd.read_col = (cur_col == 0) ? '0 : COL_W'(cur_col - 1);
        end
        in_valid <= 1'b1;
        in_command <= next_cmd.command;
        in_char_code <= next_cmd.char_code;
        in_read_row <= next_cmd.read_row;
        in_read_col <= next_cmd.read_col;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_started < holds_requested) begin
      holds_started++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: predict on accepted commands, check each result transaction
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) begin
      items_taken++;
      cell_reports.push_back(apply_command(in_command, in_char_code, in_read_row,
                                           in_read_col));
    end
    if (rst_n && out_valid && !out_stall) begin
      got_report.cell_value = out_cell_value;
      got_report.cursor_col = out_cursor_col;
      got_report.cursor_row = out_cursor_row;
      got_report.cursor_visible = out_cursor_visible;
      if (cell_reports.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        want_report = cell_reports.pop_front();
        if (got_report.cell_value !== want_report.cell_value)
          report_mismatch($sformatf("cell_value got %0h expected %0h",
                                    got_report.cell_value, want_report.cell_value));
        if (got_report.cursor_col !== want_report.cursor_col)
          report_mismatch($sformatf("cursor_col got %0d expected %0d",
                                    got_report.cursor_col, want_report.cursor_col));
        if (got_report.cursor_row !== want_report.cursor_row)
          report_mismatch($sformatf("cursor_row got %0d expected %0d",
                                    got_report.cursor_row, want_report.cursor_row));
        if (got_report.cursor_visible !== want_report.cursor_visible)
          report_mismatch($sformatf("cursor_visible got %0b expected %0b",
                                    got_report.cursor_visible, want_report.cursor_visible));
      end
      results_seen++;
    end
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    int send_pcts [PHASES];
    int stall_pcts [PHASES];
    send_pcts = '{0, 57, 0, 22};
    stall_pcts = '{0, 0, 57, 22};
    blank_screen();
    cur_col = 0;
    cur_row = 0;
    cur_shown = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: cursor marking, special characters, range edges, spare codes
    push_item(CMD_READ, 8'hFF, '0, '0, AIM_NONE);
    push_plain(CMD_SHOW, 8'h00);
    push_plain(CMD_SHOW, 8'hFF);
    push_item(CMD_READ, 8'h00, '0, '0, AIM_NONE);
    push_plain(CMD_PUT, CHAR_A);
    push_plain(CMD_PUT, 8'hFF);
    push_plain(CMD_PUT, 8'h00);
    push_item(CMD_READ, 8'h00, '0, COL_W'(1), AIM_NONE);
    push_plain(CMD_PUT, CHAR_CR);
    push_item(CMD_READ, 8'h00, '0, '0, AIM_CURSOR);
    push_plain(CMD_FWD, 8'h00);
    push_plain(CMD_LF, 8'h00);
    push_plain(CMD_PUT, CHAR_LF);
    push_plain(CMD_NEWLINE, 8'hFF);
    push_plain(CMD_HIDE, 8'h00);
    push_plain(CMD_HIDE, 8'hFF);
    push_item(CMD_READ, 8'h00, '0, '0, AIM_NONE);
    push_item(CMD_READ, 8'hFF, '1, '1, AIM_NONE);
    push_item(CMD_READ, 8'h00, ROW_W'(DEF_ROWS), '0, AIM_NONE);
    push_item(CMD_READ, 8'h00, '0, COL_W'(DEF_COLS), AIM_NONE);
    push_item(CMD_READ, 8'h00, ROW_W'(DEF_ROWS - 1), COL_W'(DEF_COLS - 1), AIM_NONE);
    push_item(CMD_FIRST_SPARE, 8'hFF, '1, '1, AIM_NONE);
    push_item(CMD_LAST_SPARE, 8'h00, '0, '0, AIM_NONE);
    push_plain(CMD_SCROLL, 8'h00);
    push_item(CMD_READ, 8'h00, '0, '0, AIM_NONE);
    push_plain(CMD_CLEAR, 8'hFF);
    wait_drained();

    // random phases, each drained before the next; the first with a long hold-off
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = send_pcts[ph];
      stall_pct = stall_pcts[ph];
      if (ph == 0) holds_requested++;
      queue_random(RANDOM_ITEMS / PHASES);
      wait_drained();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && cell_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ttcb_pkg.sv
rtl/ttcb_ram.sv
rtl/ttcb_ctrl.sv
rtl/ttcb_dp.sv
rtl/text_terminal_char_buffer.sv
dv/text_terminal_char_buffer_test.sv
